/* src/pwd_pkg.sv */
package pwd_pkg;

    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 64;

    localparam logic [CfgIndexW-1:0] CFG_HASH_W0  = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_HASH_W1  = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_HASH_W2  = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_MAX_LEN  = 3'd3;

    localparam logic [20:0] LenCap   = 21'd1048576;
    localparam logic [20:0] LenReset = 21'd262144;

    localparam logic [6:0] HsLastPos = 7'd67;
    localparam logic [7:0] PstrLen   = 8'd19;
    localparam logic [6:0] PstrLast  = 7'd19;
    localparam logic [6:0] HashFirst = 7'd28;
    localparam logic [6:0] HashEnd   = 7'd48;
    localparam logic [4:0] HashLast  = 5'd19;
    localparam logic [6:0] LenLast   = 7'd3;

    typedef enum logic [2:0] {
        EV_HS_OK    = 3'd0,
        EV_HS_BAD   = 3'd1,
        EV_KEEP     = 3'd2,
        EV_MSG      = 3'd3,
        EV_PAYLOAD  = 3'd4,
        EV_OVERSIZE = 3'd5
    } event_t;

    localparam logic [7:0] ID_CHOKE      = 8'd0;
    localparam logic [7:0] ID_UNCHOKE    = 8'd1;
    localparam logic [7:0] ID_INTEREST   = 8'd2;
    localparam logic [7:0] ID_UNINTEREST = 8'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  msg_id;
        logic [19:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
        logic        peer_is_choking;
        logic        peer_is_interested;
    } out_item_t;

    // protocol name string of the handshake, one byte per index
    function automatic logic [7:0] pstr_byte(input logic [4:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            5'd0:    b = 8'h42;
            5'd1:    b = 8'h69;
            5'd2:    b = 8'h74;
            5'd3:    b = 8'h54;
            5'd4:    b = 8'h6f;
            5'd5:    b = 8'h72;
            5'd6:    b = 8'h72;
            5'd7:    b = 8'h65;
            5'd8:    b = 8'h6e;
            5'd9:    b = 8'h74;
            5'd10:   b = 8'h20;
            5'd11:   b = 8'h70;
            5'd12:   b = 8'h72;
            5'd13:   b = 8'h6f;
            5'd14:   b = 8'h74;
            5'd15:   b = 8'h6f;
            5'd16:   b = 8'h63;
            5'd17:   b = 8'h6f;
            5'd18:   b = 8'h6c;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/peer_wire_deframer.sv */
// Receive-side deframer for a peer wire link. One byte (or a restart) is taken
// per transfer on the input channel, and a new transfer can be accepted every
// cycle while in_stall is low: the whole decision for a byte is made in the
// cycle it is accepted and its result, if any, is registered in the output
// register, or in the skid register behind it, which absorbs one result while
// out_stall is high; in_stall is raised only while that skid register is
// occupied, so it is a registered signal. The 68-byte handshake is checked
// first (verdict on its last byte), then length-prefixed messages are split
// into a start event and payload byte events. After a bad handshake or an
// oversize length, bytes are dropped until a restart. Configuration writes
// take effect on the next cycle and should be issued while the block is idle.
module peer_wire_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  pwd_pkg::in_item_t                  in_item,

    output logic                               out_valid,
    input  logic                               out_stall,
    output pwd_pkg::out_item_t                 out_item,

    input  logic                               cfg_write_en,
    input  logic [pwd_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [pwd_pkg::CfgDataW-1:0]       cfg_data
);

    typedef enum logic [4:0] {
        PH_HANDSHAKE = 5'b00001,
        PH_LENGTH    = 5'b00010,
        PH_ID        = 5'b00100,
        PH_PAYLOAD   = 5'b01000,
        PH_HALT      = 5'b10000
    } phase_t;

    // configuration
    logic [63:0] hash_w0_reg;
    logic [63:0] hash_w1_reg;
    logic [31:0] hash_w2_reg;
    logic [20:0] max_len_reg;

    // deframer state
    phase_t      phase_reg, phase_next;
    logic [6:0]  pos_reg, pos_next;
    logic [31:0] accum_reg, accum_next;
    logic [20:0] left_reg, left_next;
    logic [7:0]  id_reg, id_next;
    logic        good_reg, good_next;
    logic        choke_reg, choke_next;
    logic        interest_reg, interest_next;

    // output register and skid
    logic               out_valid_reg;
    pwd_pkg::out_item_t out_item_reg;
    logic               skid_valid_reg;
    pwd_pkg::out_item_t skid_item_reg;

    logic               in_fire;
    logic               out_fire;
    logic               res_valid;
    pwd_pkg::out_item_t res;

    logic [159:0] hash_vec;
    logic [6:0]   hash_off;
    logic [4:0]   hash_sel;
    logic [7:0]   hash_byte;
    logic [7:0]   want_pstr;
    logic         byte_ok;
    logic [31:0]  new_accum;
    logic [20:0]  max_eff;
    logic [20:0]  left_dec;
    logic [31:0]  len_m1;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_w0_reg <= '0;
            hash_w1_reg <= '0;
            hash_w2_reg <= '0;
            max_len_reg <= pwd_pkg::LenReset;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                pwd_pkg::CFG_HASH_W0: hash_w0_reg <= cfg_data;
                pwd_pkg::CFG_HASH_W1: hash_w1_reg <= cfg_data;
                pwd_pkg::CFG_HASH_W2: hash_w2_reg <= cfg_data[31:0];
                pwd_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data[20:0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake byte check
    assign hash_vec  = {hash_w0_reg, hash_w1_reg, hash_w2_reg};
    assign hash_off  = pos_reg - pwd_pkg::HashFirst;
    assign hash_sel  = pwd_pkg::HashLast - hash_off[4:0];
    assign hash_byte = hash_vec[{hash_sel, 3'b000} +: 8];
    assign want_pstr = pwd_pkg::pstr_byte(5'(pos_reg - 7'd1));

    always_comb
    begin
        byte_ok = 1'b1;
        if (pos_reg == 7'd0)
        begin
            byte_ok = (in_item.rx_byte == pwd_pkg::PstrLen);
        end
        else if (pos_reg <= pwd_pkg::PstrLast)
        begin
            byte_ok = (in_item.rx_byte == want_pstr);
        end
        else if (pos_reg >= pwd_pkg::HashFirst && pos_reg < pwd_pkg::HashEnd)
        begin
            byte_ok = (in_item.rx_byte == hash_byte);
        end
    end

    assign new_accum = {accum_reg[23:0], in_item.rx_byte};
    assign max_eff   = (max_len_reg > pwd_pkg::LenCap) ? pwd_pkg::LenCap : max_len_reg;
    assign left_dec  = (left_reg != 21'd0) ? (left_reg - 21'd1) : left_reg;
    assign len_m1    = accum_reg - 32'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        accum_next    = accum_reg;
        left_next     = left_reg;
        id_next       = id_reg;
        good_next     = good_reg;
        choke_next    = choke_reg;
        interest_next = interest_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (in_fire)
        begin
            if (in_item.action)
            begin
                phase_next = PH_HANDSHAKE;
                pos_next   = '0;
                accum_next = '0;
                left_next  = '0;
                id_next    = '0;
                good_next  = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HANDSHAKE:
                    begin
                        if (!byte_ok)
                        begin
                            good_next = 1'b0;
                        end
                        if (pos_reg != pwd_pkg::HsLastPos)
                        begin
                            pos_next = pos_reg + 7'd1;
                        end
                        else
                        begin
                            pos_next   = '0;
                            accum_next = '0;
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            if (good_next)
                            begin
                                phase_next    = PH_LENGTH;
                                res.event_res = pwd_pkg::EV_HS_OK;
                            end
                            else
                            begin
                                phase_next    = PH_HALT;
                                res.event_res = pwd_pkg::EV_HS_BAD;
                            end
                        end
                    end
                    PH_LENGTH:
                    begin
                        accum_next = new_accum;
                        if (pos_reg != pwd_pkg::LenLast)
                        begin
                            pos_next = pos_reg + 7'd1;
                        end
                        else
                        begin
                            pos_next = '0;
                            if (new_accum == 32'd0)
                            begin
                                res_valid     = 1'b1;
                                res.event_res = pwd_pkg::EV_KEEP;
                                res.last      = 1'b1;
                            end
                            else if (new_accum > {11'd0, max_eff})
                            begin
                                phase_next    = PH_HALT;
                                res_valid     = 1'b1;
                                res.event_res = pwd_pkg::EV_OVERSIZE;
                            end
                            else
                            begin
                                phase_next = PH_ID;
                            end
                        end
                    end
                    PH_ID:
                    begin
                        id_next            = in_item.rx_byte;
                        left_next          = len_m1[20:0];
                        res_valid          = 1'b1;
                        res.event_res      = pwd_pkg::EV_MSG;
                        res.msg_id         = in_item.rx_byte;
                        res.payload_length = len_m1[19:0];
                        if (len_m1[20:0] == 21'd0)
                        begin
                            phase_next = PH_LENGTH;
                            accum_next = '0;
                            res.last   = 1'b1;
                            case (in_item.rx_byte)
                                pwd_pkg::ID_CHOKE:      choke_next    = 1'b1;
                                pwd_pkg::ID_UNCHOKE:    choke_next    = 1'b0;
                                pwd_pkg::ID_INTEREST:   interest_next = 1'b1;
                                pwd_pkg::ID_UNINTEREST: interest_next = 1'b0;
                                default:
                                begin
                                end
                            endcase
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        left_next          = left_dec;
                        res_valid          = 1'b1;
                        res.event_res      = pwd_pkg::EV_PAYLOAD;
                        res.msg_id         = id_reg;
                        res.payload_length = len_m1[19:0];
                        res.data_byte      = in_item.rx_byte;
                        if (left_dec == 21'd0)
                        begin
                            phase_next = PH_LENGTH;
                            accum_next = '0;
                            res.last   = 1'b1;
                            case (id_reg)
                                pwd_pkg::ID_CHOKE:      choke_next    = 1'b1;
                                pwd_pkg::ID_UNCHOKE:    choke_next    = 1'b0;
                                pwd_pkg::ID_INTEREST:   interest_next = 1'b1;
                                pwd_pkg::ID_UNINTEREST: interest_next = 1'b0;
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    PH_HALT:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        res.peer_is_choking    = choke_next;
        res.peer_is_interested = interest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HANDSHAKE;
            pos_reg      <= '0;
            accum_reg    <= '0;
            left_reg     <= '0;
            id_reg       <= '0;
            good_reg     <= 1'b1;
            choke_reg    <= 1'b1;
            interest_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            accum_reg    <= accum_next;
            left_reg     <= left_next;
            id_reg       <= id_next;
            good_reg     <= good_next;
            choke_reg    <= choke_next;
            interest_reg <= interest_next;
        end
    end

    // output register with one skid entry; skid only fills while out is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : res;
        end
        else if (res_valid)
        begin
            skid_item_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_item.action |=> phase_reg == PH_HANDSHAKE && pos_reg == 7'd0
            && good_reg)
        else $error("restart did not return to handshake start");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != 21'd0)
        else $error("payload phase with no bytes left");

    a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ID || phase_reg == PH_PAYLOAD)
            |-> accum_reg != 32'd0 && accum_reg <= {11'd0, pwd_pkg::LenCap})
        else $error("message length out of range past length check");

    a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENGTH |-> pos_reg <= pwd_pkg::LenLast)
        else $error("length byte counter overran");
`endif

endmodule

/* tb/tb_pwd_scoreboard_pkg.sv */
package tb_pwd_scoreboard_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import pwd_pkg::*;

    // protocol name carried in handshake bytes 1..19, first character in the top byte
    localparam logic [151:0] PROTO_NAME =
        152'h42_69_74_54_6f_72_72_65_6e_74_20_70_72_6f_74_6f_63_6f_6c;

    typedef enum logic [2:0] {
        RX_HANDSHAKE,
        RX_LENGTH,
        RX_ID,
        RX_BODY,
        RX_HALTED
    } rx_phase_e;

    function automatic logic [7:0] proto_name_byte(input int k);
        return PROTO_NAME[151 - 8 * k -: 8];
    endfunction

    // info hash held as one 160-bit word, hash byte 0 in the top bits
    function automatic logic [7:0] hash_byte_of(input logic [159:0] h, input int k);
        return h[159 - 8 * k -: 8];
    endfunction

    class deframe_scoreboard;

        logic [159:0] peer_hash;
        logic [20:0]  max_len;

        rx_phase_e    phase;
        logic [6:0]   byte_pos;
        logic [31:0]  len_acc;
        logic [20:0]  body_left;
        logic [7:0]   cur_id;
        logic         hs_good;
        logic         choking;
        logic         interested;

        out_item_t    expected_q[$];
        int unsigned  errors;

        function new();
            peer_hash  = '0;
            max_len    = LenReset;
            restart();
            choking    = 1'b1;
            interested = 1'b0;
            errors     = 0;
        endfunction

        // peer flags survive a restart
        function void restart();
            phase     = RX_HANDSHAKE;
            byte_pos  = '0;
            len_acc   = '0;
            body_left = '0;
            cur_id    = '0;
            hs_good   = 1'b1;
        endfunction

        function void write_register(input logic [CfgIndexW-1:0] idx,
                                     input logic [CfgDataW-1:0] data);
            case (idx)
                CFG_HASH_W0: peer_hash[159:96] = data;
                CFG_HASH_W1: peer_hash[95:32]  = data;
                CFG_HASH_W2: peer_hash[31:0]   = data[31:0];
                CFG_MAX_LEN: max_len           = data[20:0];
                default: ;
            endcase
        endfunction

        function void apply_flags();
            case (cur_id)
                ID_CHOKE:      choking    = 1'b1;
                ID_UNCHOKE:    choking    = 1'b0;
                ID_INTEREST:   interested = 1'b1;
                ID_UNINTEREST: interested = 1'b0;
                default: ;
            endcase
        endfunction

        function void queue_result(input event_t ev, input logic [7:0] id,
                                   input logic [19:0] plen, input logic [7:0] data,
                                   input logic fin);
            out_item_t r;
            r.event_res          = ev;
            r.msg_id             = id;
            r.payload_length     = plen;
            r.data_byte          = data;
            r.last               = fin;
            r.peer_is_choking    = choking;
            r.peer_is_interested = interested;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void note_transfer(input in_item_t it);
            logic [7:0]  b;
            logic [20:0] cap;
            logic        fin;
            b = it.rx_byte;
            if (it.action) begin
                restart();
                return;
            end
            case (phase)
                RX_HANDSHAKE: begin
                    if (byte_pos == 7'd0) begin
                        if (b != PstrLen) hs_good = 1'b0;
                    end else if (byte_pos <= PstrLast) begin
                        if (b != proto_name_byte(byte_pos - 1)) hs_good = 1'b0;
                    end else if (byte_pos >= HashFirst && byte_pos < HashEnd) begin
                        if (b != hash_byte_of(peer_hash, byte_pos - HashFirst)) hs_good = 1'b0;
                    end
                    if (byte_pos != HsLastPos) begin
                        byte_pos++;
                    end else begin
                        byte_pos = '0;
                        len_acc  = '0;
                        if (hs_good) begin
                            phase = RX_LENGTH;
                            queue_result(EV_HS_OK, '0, '0, '0, 1'b1);
                        end else begin
                            phase = RX_HALTED;
                            queue_result(EV_HS_BAD, '0, '0, '0, 1'b1);
                        end
                    end
                end
                RX_LENGTH: begin
                    len_acc = {len_acc[23:0], b};
                    if (byte_pos != LenLast) begin
                        byte_pos++;
                    end else begin
                        byte_pos = '0;
                        cap = (max_len > LenCap) ? LenCap : max_len;
                        if (len_acc == '0) begin
                            queue_result(EV_KEEP, '0, '0, '0, 1'b1);
                        end else if (len_acc > {11'd0, cap}) begin
                            phase = RX_HALTED;
                            queue_result(EV_OVERSIZE, '0, '0, '0, 1'b0);
                        end else begin
                            phase = RX_ID;
                        end
                    end
                end
                RX_ID: begin
                    cur_id    = b;
                    body_left = len_acc[20:0] - 21'd1;
                    if (body_left == '0) begin
                        apply_flags();
                        phase   = RX_LENGTH;
                        len_acc = '0;
                        queue_result(EV_MSG, cur_id, '0, '0, 1'b1);
                    end else begin
                        phase = RX_BODY;
                        queue_result(EV_MSG, cur_id, body_left[19:0], '0, 1'b0);
                    end
                end
                RX_BODY: begin
                    fin = 1'b0;
                    cap = {1'b0, len_acc[19:0] - 20'd1};
                    if (body_left != '0) body_left--;
                    if (body_left == '0) begin
                        fin = 1'b1;
                        apply_flags();
                        phase   = RX_LENGTH;
                        len_acc = '0;
                    end
                    queue_result(EV_PAYLOAD, cur_id, cap[19:0], b, fin);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input logic [19:0] want,
                                    input logic [19:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got %0h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("msg_id", want.msg_id, got.msg_id);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("last", want.last, got.last);
            compare_field("peer_is_choking", want.peer_is_choking, got.peer_is_choking);
            compare_field("peer_is_interested", want.peer_is_interested,
                          got.peer_is_interested);
        endfunction

    endclass

endpackage

/* tb/tb_peer_wire_deframer.sv */
module tb_peer_wire_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import pwd_pkg::*;
    import tb_pwd_scoreboard_pkg::*;

    // an index past the register file; writes to it must be dropped
    localparam logic [CfgIndexW-1:0] CFG_SPARE = 3'd6;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;
    logic                 cfg_write_en;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    deframe_scoreboard sb;
    bit                calm;
    bit                hold_req;
    int unsigned       sent;

    peer_wire_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_peer_wire_deframer: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) sb.check_result(out_item);
            if (in_valid && !in_stall) sb.note_transfer(in_item);
        end
    end

    // receiver: random hold-off before each transfer, one long hold on request
    initial
    begin
        int unsigned n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = 120;
            end
            else
            begin
                n = calm ? 0 : $urandom_range(0, 14);
            end
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        in_item_t    it;
        int unsigned gap;
        it.action  = act;
        it.rx_byte = b;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic restart_link();
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic send_noise(input int unsigned count);
        repeat (count) send_item(1'b0, 8'($urandom));
    endtask

    // handshake bytes first..lastp; the byte at bad_at is corrupted
    task automatic send_hs_range(input int first, input int lastp, input int bad_at);
        logic [7:0] b;
        for (int p = first; p <= lastp; p++)
        begin
            if (p == 0)
                b = PstrLen;
            else if (p <= PstrLast)
                b = proto_name_byte(p - 1);
            else if (p >= HashFirst && p < HashEnd)
                b = hash_byte_of(sb.peer_hash, p - HashFirst);
            else
                b = 8'($urandom);
            if (p == bad_at) b ^= 8'($urandom_range(1, 255));
            send_item(1'b0, b);
        end
    endtask

    // length prefix, then tail bytes: the id first, the rest random payload
    task automatic send_frame(input logic [31:0] len, input logic [7:0] id,
                              input int unsigned tail);
        for (int k = 3; k >= 0; k--) send_item(1'b0, len[8 * k +: 8]);
        if (tail != 0) send_item(1'b0, id);
        for (int unsigned k = 1; k < tail; k++) send_item(1'b0, 8'($urandom));
    endtask

    task automatic fresh_link();
        int bad_at;
        restart_link();
        if ($urandom_range(0, 4) == 0)
        begin
            bad_at = $urandom_range(0, 1) ? $urandom_range(0, 19) : $urandom_range(28, 47);
            send_hs_range(0, HsLastPos, bad_at);
            send_noise($urandom_range(0, 3));
            restart_link();
        end
        send_hs_range(0, HsLastPos, -1);
    endtask

    // the edge after the last transfer lets the scoreboard queue its result
    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        sb.write_register(idx, data);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // unused upper data bits carry junk
    task automatic set_hash(input logic [159:0] h);
        write_reg(CFG_HASH_W0, h[159:96]);
        write_reg(CFG_HASH_W1, h[95:32]);
        write_reg(CFG_HASH_W2, {32'($urandom), h[31:0]});
    endtask

    task automatic set_max(input logic [20:0] m);
        write_reg(CFG_MAX_LEN, {32'($urandom), 11'($urandom), m});
    endtask

    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        case ($urandom_range(0, 5))
            0:       id = ID_CHOKE;
            1:       id = ID_UNCHOKE;
            2:       id = ID_INTEREST;
            3:       id = ID_UNINTEREST;
            default: id = 8'($urandom);
        endcase
        return id;
    endfunction

    initial
    begin
        logic [20:0]  mx;
        logic [31:0]  len;
        int unsigned  eff;
        int unsigned  stop;
        int unsigned  pick;

        sb       = new();
        calm     = 1'b0;
        hold_req = 1'b0;
        sent     = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_HASH_W0;
        cfg_data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: all-zero hash, default maximum
        send_hs_range(0, HsLastPos, -1);
        send_frame(32'd0, ID_CHOKE, 0);
        send_frame(32'd1, ID_UNCHOKE, 1);
        send_frame(32'd1, ID_INTEREST, 1);
        send_frame(32'd3, ID_CHOKE, 3);
        send_frame(32'd2, ID_UNINTEREST, 2);
        send_frame(32'd4, 8'hff, 4);
        send_frame(32'd9, ID_UNCHOKE, 3);
        restart_link();
        send_hs_range(0, 10, -1);
        restart_link();
        // bad name length, then bytes dropped while halted
        send_hs_range(0, HsLastPos, 0);
        send_noise(4);
        restart_link();

        // registers rewritten partway through a handshake, before its hash bytes
        send_hs_range(0, HashFirst - 1, -1);
        go_idle();
        set_hash({$urandom, $urandom, $urandom, $urandom, $urandom});
        set_max(21'h1fffff);
        send_hs_range(HashFirst, HsLastPos, -1);
        // maximum above the cap is clamped
        send_frame(32'h0010_0001, ID_CHOKE, 0);
        restart_link();
        send_hs_range(0, HsLastPos, $urandom_range(28, 47));
        restart_link();
        send_hs_range(0, HsLastPos, -1);
        send_frame(32'h0010_0000, ID_INTEREST, 3);
        restart_link();

        for (int ph = 0; ph < 5; ph++)
        begin
            go_idle();
            case (ph)
                0:       mx = 21'd8;
                1:       mx = LenCap;
                2:       mx = 21'h1fffff;
                3:       mx = 21'd1;
                default: mx = 21'($urandom_range(2, 40));
            endcase
            set_max(mx);
            if (ph == 3) write_reg(CFG_SPARE, {$urandom, $urandom});
            calm = (ph == 2);
            eff  = (mx > LenCap) ? LenCap : mx;
            // a new handshake is needed only when the link is not framing
            if (sb.phase != RX_LENGTH)
            begin
                set_hash('1);
                fresh_link();
            end
            stop = sent + 10;
            if (ph == 1)
            begin
                // receiver holds off while bytes keep coming
                calm     = 1'b1;
                hold_req = 1'b1;
                send_frame(32'd24, pick_id(), 24);
                calm     = 1'b0;
            end
            while (sent < stop)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    send_frame(32'd0, ID_CHOKE, 0);
                end
                else if (pick < 12)
                begin
                    len = $urandom_range(0, 1) ? eff + 1 : $urandom;
                    if (len <= eff) len = eff + 1;
                    send_frame(len, ID_CHOKE, 0);
                    send_noise($urandom_range(0, 3));
                    fresh_link();
                end
                else if (pick < 15)
                begin
                    len = $urandom_range(1, eff);
                    send_frame(len, pick_id(), $urandom_range(0, (len < 6) ? len : 6));
                    fresh_link();
                end
                else
                begin
                    len = $urandom_range(1, (eff < 12) ? eff : 12);
                    send_frame(len, pick_id(), len);
                end
            end
        end

        // zero maximum: any nonzero length is oversize
        calm = 1'b0;
        go_idle();
        set_max(21'd0);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        send_frame(32'd0, ID_CHOKE, 0);
        send_frame(32'd1, ID_CHOKE, 0);
        send_noise(3);
        restart_link();

        go_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_peer_wire_deframer: clean");
        else
            $display("tb_peer_wire_deframer: errors");
        $finish;
    end

endmodule
